// ===== hw/rtl/tbs_pkg.sv =====
// ---------------------------------------------------------------------------
// tbs_pkg
// Shared types, codes and sizes for the token bucket traffic shaper.
// ---------------------------------------------------------------------------
package tbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BUCKET_DEPTH    = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int BURST_W         = $clog2(MAX_RESULTS);

  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int KIND_W = 3;
  localparam int CNT_W  = 5;
  localparam int LIM_W  = 5;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [OP_W-1:0] OP_ARRIVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TOKEN    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;
  localparam logic [OP_W-1:0] OP_STATUS   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_SENT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

  localparam logic REG_INGRESS_LIMIT = 1'b0;
  localparam logic REG_TOKEN_LIMIT   = 1'b1;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [LIM_W-1:0] ingress_limit;
    logic [LIM_W-1:0] token_limit;
  } cfg_t;

endpackage

// ===== hw/rtl/tbs_in_if.sv =====
// ---------------------------------------------------------------------------
// tbs_in_if
// Event channel: valid/ready handshake with op code and packet id.
// ---------------------------------------------------------------------------
interface tbs_in_if;
  import tbs_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [ID_W-1:0] packet_id;

  modport source (output valid, output op, output packet_id, input ready);
  modport sink   (input valid, input op, input packet_id, output ready);

endinterface

// ===== hw/rtl/tbs_out_if.sv =====
// ---------------------------------------------------------------------------
// tbs_out_if
// Result channel: valid/ready handshake with result kind, id and counts.
// ---------------------------------------------------------------------------
interface tbs_out_if;
  import tbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   sent_id;
  logic [CNT_W-1:0]  tokens_left;
  logic [CNT_W-1:0]  queued;
  logic              last;

  modport source (output valid, output kind, output sent_id, output tokens_left,
                  output queued, output last, input ready);
  modport sink   (input valid, input kind, input sent_id, input tokens_left,
                  input queued, input last, output ready);

endinterface

// ===== hw/rtl/tbs_ram.sv =====
// ---------------------------------------------------------------------------
// tbs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tbs_regs.sv =====
// ---------------------------------------------------------------------------
// tbs_regs
// APB register file holding the ingress and token limits.
// ---------------------------------------------------------------------------
module tbs_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbs_pkg::APB_AW-1:0]  paddr,
  input  logic [tbs_pkg::APB_DW-1:0]  pwdata,
  output logic [tbs_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output tbs_pkg::cfg_t               cfg
);
  import tbs_pkg::*;

  cfg_t       cfg_r;
  logic       reg_idx;
  logic       wr_hit;
  logic [LIM_W-1:0] rd_val;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ingress_limit <= LIMIT_RESET;
      cfg_r.token_limit   <= LIMIT_RESET;
    end else if (wr_hit) begin
      unique case (reg_idx)
        REG_INGRESS_LIMIT: cfg_r.ingress_limit <= pwdata[LIM_W-1:0];
        REG_TOKEN_LIMIT:   cfg_r.token_limit   <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INGRESS_LIMIT: rd_val = cfg_r.ingress_limit;
      REG_TOKEN_LIMIT:   rd_val = cfg_r.token_limit;
    endcase
  end

  assign prdata = APB_DW'(rd_val);
  assign cfg    = cfg_r;

endmodule

// ===== hw/rtl/tbs_ctrl.sv =====
// ---------------------------------------------------------------------------
// tbs_ctrl
// Bucket and queue bookkeeping, dispatch sequencer and result register.
// ---------------------------------------------------------------------------
module tbs_ctrl #(
  parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tbs_pkg::cfg_t            cfg,
  tbs_in_if.sink                   in_ch,
  tbs_out_if.source                out_ch,
  output logic                     ram_wr_en,
  output logic [PTR_W-1:0]         ram_wr_addr,
  output logic [tbs_pkg::ID_W-1:0] ram_wr_data,
  output logic                     ram_rd_en,
  output logic [PTR_W-1:0]         ram_rd_addr,
  input  logic [tbs_pkg::ID_W-1:0] ram_rd_data,
  output logic                     busy
);
  import tbs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic               state_r, state_nxt;
  logic [CNT_W-1:0]   tok_r, tok_nxt;
  logic [CNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [BURST_W-1:0] burst_r, burst_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [CNT_W-1:0]   otok_r, otok_nxt;
  logic [CNT_W-1:0]   oq_r, oq_nxt;
  logic               last_r, last_nxt;

  logic               out_free;
  logic               acc;
  logic               can_queue;
  logic               can_tok;
  logic               fin;
  logic [PTR_W-1:0]   head_inc;
  logic [PTR_W-1:0]   tail_inc;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_ch.valid && in_ch.ready;
  assign can_queue = (qcnt_r < cfg.ingress_limit) && (32'(qcnt_r) < QUEUE_DEPTH);
  assign can_tok   = (tok_r < cfg.token_limit) && (32'(tok_r) < BUCKET_DEPTH);
  assign head_inc  = next_slot(head_r);
  assign tail_inc  = next_slot(tail_r);
  assign fin       = (burst_r == BURST_W'(MAX_RESULTS - 1)) ||
                     (tok_r == CNT_W'(1)) || (qcnt_r == CNT_W'(1));

  assign ram_wr_en   = acc && (in_ch.op == OP_ARRIVE) && can_queue;
  assign ram_wr_addr = tail_r;
  assign ram_wr_data = in_ch.packet_id;

  always_comb begin
    state_nxt     = state_r;
    tok_nxt       = tok_r;
    qcnt_nxt      = qcnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    burst_nxt     = burst_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    otok_nxt      = otok_r;
    oq_nxt        = oq_r;
    last_nxt      = last_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_valid_nxt = 1'b1;
          id_nxt        = '0;
          otok_nxt      = tok_r;
          oq_nxt        = qcnt_r;
          last_nxt      = 1'b1;
          kind_nxt      = KIND_STATUS;
          unique case (in_ch.op)
            OP_ARRIVE: begin
              if (can_queue) begin
                tail_nxt = tail_inc;
                qcnt_nxt = qcnt_r + CNT_W'(1);
                oq_nxt   = qcnt_r + CNT_W'(1);
                kind_nxt = KIND_ACCEPTED;
              end else begin
                kind_nxt = KIND_DROPPED;
                id_nxt   = in_ch.packet_id;
              end
            end
            OP_TOKEN: begin
              if (can_tok) begin
                tok_nxt  = tok_r + CNT_W'(1);
                otok_nxt = tok_r + CNT_W'(1);
              end
            end
            OP_DISPATCH: begin
              if ((tok_r != '0) && (qcnt_r != '0)) begin
                out_valid_nxt = out_valid_r && !out_ch.ready;
                kind_nxt      = kind_r;
                id_nxt        = id_r;
                otok_nxt      = otok_r;
                oq_nxt        = oq_r;
                last_nxt      = last_r;
                ram_rd_en     = 1'b1;
                burst_nxt     = '0;
                state_nxt     = ST_DISP;
              end else begin
                kind_nxt = KIND_NONE;
              end
            end
            default: begin
              kind_nxt = KIND_STATUS;
            end
          endcase
        end
      end
      ST_DISP: begin
        if (out_free) begin
          head_nxt      = head_inc;
          tok_nxt       = tok_r - CNT_W'(1);
          qcnt_nxt      = qcnt_r - CNT_W'(1);
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_SENT;
          id_nxt        = ram_rd_data;
          otok_nxt      = tok_r - CNT_W'(1);
          oq_nxt        = qcnt_r - CNT_W'(1);
          last_nxt      = fin;
          if (fin) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = head_inc;
            burst_nxt   = burst_r + BURST_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok_r       <= '0;
      qcnt_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_r       <= tok_nxt;
      qcnt_r      <= qcnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    id_r   <= id_nxt;
    otok_r <= otok_nxt;
    oq_r   <= oq_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.sent_id     = id_r;
  assign out_ch.tokens_left = otok_r;
  assign out_ch.queued      = oq_r;
  assign out_ch.last        = last_r;
  assign busy               = (state_r == ST_DISP);

endmodule

// ===== hw/rtl/token_bucket_traffic_shaper_top.sv =====
// ---------------------------------------------------------------------------
// token_bucket_traffic_shaper_top
// Token bucket shaper: ingress queue in RAM, bucket counter, dispatch bursts.
//
//   channel   direction  payload
//   in_ch     sink       op, packet_id
//   out_ch    source     kind, sent_id, tokens_left, queued, last
//   apb       slave      ingress_limit @0x0, token_limit @0x4
//
// Arrival, token and status transactions run back to back unless out_ch stalls.
// A dispatch first reads the queue head, then releases the queued packets in
// turn through the single read port of the packet RAM.
// Reset is synchronous; no clearing pass, the queue RAM is never read unwritten.
// A stalled result stays in the result register; in_ch waits.
// ---------------------------------------------------------------------------
module token_bucket_traffic_shaper_top #(
  parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tbs_in_if.sink                     in_ch,
  tbs_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbs_pkg::APB_AW-1:0] paddr,
  input  logic [tbs_pkg::APB_DW-1:0] pwdata,
  output logic [tbs_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import tbs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cfg_t             cfg;
  logic             ram_wr_en;
  logic [PTR_W-1:0] ram_wr_addr;
  logic [ID_W-1:0]  ram_wr_data;
  logic             ram_rd_en;
  logic [PTR_W-1:0] ram_rd_addr;
  logic [ID_W-1:0]  ram_rd_data;
  logic             busy;

  tbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbs_ram #(
    .WIDTH (ID_W),
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W)
  ) u_pkt_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tbs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .busy        (busy)
  );

`ifndef NO_ASSERTIONS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("input accepted during dispatch burst");

  a_sent_not_last_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_SENT) && !out_ch.last) |->
      ((out_ch.tokens_left != '0) && (out_ch.queued != '0)))
    else $error("burst continues with empty bucket or queue");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == KIND_NONE)) |-> out_ch.last)
    else $error("empty dispatch result without last mark");

  a_unused_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && ((out_ch.kind == KIND_ACCEPTED) || (out_ch.kind == KIND_STATUS) ||
                      (out_ch.kind == KIND_NONE))) |-> (out_ch.sent_id == '0))
    else $error("sent_id set on a result that carries no packet");
`endif

endmodule
